@@ sv/mttf_pkg.sv @@
// Shared types, constants and arithmetic helpers of the minimum-time trajectory filter.
package mttf_pkg;

  localparam int VW = 32;                  // width of every Q16.16 port value
  localparam int IW = 64;                  // internal width, 32 fraction bits
  localparam int MW = 17;                  // width of the surface index m
  localparam int BW = 5;                   // width of the m search bit index
  localparam int DIV_BITS = 4;             // quotient bits retired per divider cycle
  localparam int DIV_CW = 5;               // divider step counter width
  localparam int DIV_WIDE_CYC = (IW + 32) / DIV_BITS;
  localparam int DIV_NARROW_CYC = IW / DIV_BITS;
  localparam int AW = 5;                   // APB address width

  localparam logic [IW-1:0] WLIM_U = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [65:0] WLIM66 = 66'sh0_3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [65:0] VMAX66 = 66'sh0_0000_0000_7FFF_FFFF;
  localparam logic signed [65:0] VMIN66 = -VMAX66 - 66'sd1;
  localparam logic [32:0] SS_ONE = 33'h1_0000_0000;

  localparam logic [30:0] RST_MAX_VEL = 31'd65536;
  localparam logic [30:0] RST_MAX_ACC = 31'd65536;
  localparam logic [31:0] RST_PERIOD = 32'd4294967;

  typedef enum logic [2:0] {
    REG_MAX_VEL,
    REG_MAX_ACC,
    REG_PERIOD,
    REG_USE_MPOS,
    REG_USE_MVEL
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_TRI,
    ST_SIG1,
    ST_SIG2,
    ST_GATE1,
    ST_GATE2,
    ST_ACC,
    ST_VEL1,
    ST_VEL2,
    ST_POS1,
    ST_POS2,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    D_FD,
    D_EK,
    D_EK2,
    D_ZA,
    D_ZK,
    D_ZK2,
    D_M
  } div_sel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DSTORE,
    OP_TRI,
    OP_SIG1,
    OP_SIG2,
    OP_GATE1,
    OP_GATE2,
    OP_ACC,
    OP_VEL1,
    OP_VEL2,
    OP_POS1,
    OP_POS2,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t   op;
    logic     div_start;
    div_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic need_fd;
    logic tri_last;
    logic out_busy;
  } dp_status_t;

  function automatic logic [IW-1:0] mag(input logic signed [IW-1:0] a);
    mag = a[IW-1] ? IW'(-a) : IW'(a);
  endfunction

  function automatic logic signed [IW-1:0] clamp_w(input logic signed [65:0] v);
    if (v > WLIM66) begin
      clamp_w = IW'(WLIM66);
    end else if (v < -WLIM66) begin
      clamp_w = IW'(-WLIM66);
    end else begin
      clamp_w = IW'(v);
    end
  endfunction

  function automatic logic signed [VW-1:0] clamp_v(input logic signed [65:0] v);
    if (v > VMAX66) begin
      clamp_v = VW'(VMAX66);
    end else if (v < VMIN66) begin
      clamp_v = VW'(VMIN66);
    end else begin
      clamp_v = VW'(v);
    end
  endfunction

  function automatic logic signed [IW-1:0] sadd(input logic signed [IW-1:0] a,
                                                input logic signed [IW-1:0] b);
    sadd = clamp_w(66'(a) + 66'(b));
  endfunction

endpackage

@@ sv/minimum_time_trajectory_filter.sv @@
// Minimum-time trajectory filter for one axis: one input word (destination and measured
// position and velocity) yields one output word (commanded position, velocity and
// acceleration), all signed Q16.16. Words are handled one at a time. Nearly all of the
// time taken by a word is spent in the single shared divider, which retires four quotient
// bits per cycle (with a 32-bit fraction shift for every division but the one by m) and
// is used six or seven times per word, seven when the velocity comes from a finite
// difference, plus a bit-by-bit search for m. The next word is accepted as soon as the
// previous result sits in the output register, so a slow consumer delays only the end of
// the following word.
module minimum_time_trajectory_filter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mttf_pkg::AW-1:0]    paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         dest_position,
  input  logic signed [31:0]         dest_velocity,
  input  logic signed [31:0]         measured_position,
  input  logic signed [31:0]         measured_velocity,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         cmd_position,
  output logic signed [31:0]         cmd_velocity,
  output logic signed [31:0]         cmd_acceleration
);
  import mttf_pkg::*;

  logic [30:0] max_velocity, max_acceleration;
  logic [31:0] sample_period;
  logic        use_measured_position, use_measured_velocity;
  reg_idx_t    idx;
  dp_cmd_t     cmd;
  dp_status_t  status;

  assign pready = 1'b1;
  assign idx = reg_idx_t'(paddr[AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_velocity <= RST_MAX_VEL;
      max_acceleration <= RST_MAX_ACC;
      sample_period <= RST_PERIOD;
      use_measured_position <= 1'b1;
      use_measured_velocity <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_MAX_VEL: max_velocity <= pwdata[30:0];
        REG_MAX_ACC: max_acceleration <= pwdata[30:0];
        REG_PERIOD: sample_period <= pwdata;
        REG_USE_MPOS: use_measured_position <= pwdata[0];
        REG_USE_MVEL: use_measured_velocity <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_VEL: prdata = {1'b0, max_velocity};
      REG_MAX_ACC: prdata = {1'b0, max_acceleration};
      REG_PERIOD: prdata = sample_period;
      REG_USE_MPOS: prdata = {31'b0, use_measured_position};
      REG_USE_MVEL: prdata = {31'b0, use_measured_velocity};
      default: prdata = '0;
    endcase
  end

  mttf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  mttf_dp u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .status                (status),
    .max_velocity          (max_velocity),
    .max_acceleration      (max_acceleration),
    .sample_period         (sample_period),
    .use_measured_position (use_measured_position),
    .use_measured_velocity (use_measured_velocity),
    .dest_position         (dest_position),
    .dest_velocity         (dest_velocity),
    .measured_position     (measured_position),
    .measured_velocity     (measured_velocity),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .cmd_position          (cmd_position),
    .cmd_velocity          (cmd_velocity),
    .cmd_acceleration      (cmd_acceleration)
  );

endmodule

@@ sv/mttf_div.sv @@
// Iterative restoring divider: magnitude times 2^32 (or times 1) over a 32-bit divisor,
// saturating at the internal limit.
module mttf_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                wide,
  input  logic [63:0]         dividend,
  input  logic [31:0]         divisor,
  output logic                done,
  output logic [63:0]         quotient
);
  import mttf_pkg::*;

  logic              busy;
  logic [IW-1:0]     dvd, dvd_next;
  logic [31:0]       r, r_next;
  logic [IW-1:0]     q, q_next;
  logic              sat, sat_next;
  logic              zero;
  logic [DIV_CW-1:0] cnt;

  always_comb begin
    logic [32:0] trial;
    dvd_next = dvd;
    r_next = r;
    q_next = q;
    sat_next = sat;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {r_next, dvd_next[IW-1]};
      dvd_next = {dvd_next[IW-2:0], 1'b0};
      if (!sat_next) begin
        if (trial >= {1'b0, divisor}) begin
          r_next = 32'(trial - {1'b0, divisor});
          q_next = {q_next[IW-2:0], 1'b1};
        end else begin
          r_next = trial[31:0];
          q_next = {q_next[IW-2:0], 1'b0};
        end
        if (q_next > WLIM_U) begin
          sat_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= wide ? DIV_CW'(DIV_WIDE_CYC) : DIV_CW'(DIV_NARROW_CYC);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      r <= '0;
      q <= '0;
      sat <= 1'b0;
      zero <= (dividend == '0);
    end else if (busy) begin
      dvd <= dvd_next;
      r <= r_next;
      q <= q_next;
      sat <= sat_next;
    end
  end

  // A zero dividend gives zero even for a zero divisor.
  assign quotient = zero ? '0 : (sat ? WLIM_U : q);

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held for two cycles");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule

@@ sv/mttf_dp.sv @@
// Datapath of the trajectory filter: operand registers, shared divider, multipliers and
// the output word register.
module mttf_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  mttf_pkg::dp_cmd_t        cmd,
  output mttf_pkg::dp_status_t     status,
  input  logic [30:0]              max_velocity,
  input  logic [30:0]              max_acceleration,
  input  logic [31:0]              sample_period,
  input  logic                     use_measured_position,
  input  logic                     use_measured_velocity,
  input  logic signed [31:0]       dest_position,
  input  logic signed [31:0]       dest_velocity,
  input  logic signed [31:0]       measured_position,
  input  logic signed [31:0]       measured_velocity,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [31:0]       cmd_position,
  output logic signed [31:0]       cmd_velocity,
  output logic signed [31:0]       cmd_acceleration
);
  import mttf_pkg::*;

  logic signed [VW-1:0] cp, cv, dp_r, dv_r, prev_pos, prev_cmd;
  logic signed [VW:0]   fd_diff;
  logic                 need_fd, prev_valid;
  logic signed [IW-1:0] ek, ek2, za, zk, zk2, zm, sig;
  logic [MW-1:0]        m;
  logic [31:0]          tri_n;
  logic [BW-1:0]        bidx;
  logic                 sig_pos, sig_neg, gpos, gzero, div_neg;
  logic [32:0]          ss_mag;
  logic signed [33:0]   x;
  logic [62:0]          ta;
  logic [IW-1:0]        prod;
  logic signed [VW-1:0] acc, vel, pos;
  logic signed [VW:0]   pv, pp;

  logic signed [IW-1:0] num, q_s, ek2_half, mterm;
  logic [31:0]          den;
  logic                 div_done, wide;
  logic [IW-1:0]        quot;
  logic signed [VW-1:0] cp_new;
  logic [MW-1:0]        c;
  logic [2*MW-1:0]      cprod;
  logic [IW-1:0]        sig_mag;
  logic [31:0]          amag, acc_mag, vel_mag;
  logic [63:0]          pv_full, pp_full;

  assign cp_new = use_measured_position ? measured_position : prev_cmd;
  assign ek2_half = $signed(ek2 + IW'(ek2[IW-1])) >>> 1;

  always_comb begin
    wide = 1'b1;
    den = sample_period;
    unique case (cmd.sel)
      D_FD: num = IW'(fd_diff);
      D_EK: begin
        num = IW'(cp) - IW'(dp_r);
        den = {1'b0, max_acceleration};
      end
      D_EK2: begin
        num = IW'(cv) - IW'(dv_r);
        den = {1'b0, max_acceleration};
      end
      D_ZA: num = ek;
      D_ZK: num = sadd(za, ek2_half);
      D_ZK2: num = ek2;
      D_M: begin
        num = zk;
        den = 32'(m);
        wide = 1'b0;
      end
      default: num = '0;
    endcase
  end

  mttf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .wide     (wide),
    .dividend (mag(num)),
    .divisor  (den),
    .done     (div_done),
    .quotient (quot)
  );

  assign q_s = div_neg ? -$signed(quot) : $signed(quot);

  // One step of the search for the largest m with m(m-1) <= tri_n.
  assign c = m | (MW'(1) << bidx);
  assign cprod = (2*MW)'(c) * (2*MW)'(c - 1'b1);

  assign mterm = IW'(m - 1'b1) << 31;
  assign sig_mag = mag(sig);
  assign amag = gpos ? prod[63:32] : (gzero ? 32'(prod[63:33]) : '0);
  assign acc_mag = acc[VW-1] ? 32'(-acc) : 32'(acc);
  assign vel_mag = vel[VW-1] ? 32'(-vel) : 32'(vel);
  assign pv_full = 64'(acc_mag) * 64'(sample_period);
  assign pp_full = 64'(vel_mag) * 64'(sample_period);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pos <= '0;
      prev_cmd <= '0;
      prev_valid <= 1'b0;
      need_fd <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.op == OP_LOAD) begin
        prev_pos <= cp_new;
        prev_valid <= 1'b1;
        need_fd <= !use_measured_velocity && prev_valid;
      end
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
        prev_cmd <= pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_neg <= num[IW-1];
    end
    unique case (cmd.op)
      OP_LOAD: begin
        cp <= cp_new;
        cv <= use_measured_velocity ? measured_velocity : '0;
        fd_diff <= (VW+1)'(cp_new) - (VW+1)'(prev_pos);
        dp_r <= dest_position;
        dv_r <= dest_velocity;
      end
      OP_DSTORE: begin
        unique case (cmd.sel)
          D_FD: cv <= clamp_v(66'(q_s));
          D_EK: ek <= q_s;
          D_EK2: ek2 <= q_s;
          D_ZA: za <= q_s;
          D_ZK: begin
            zk <= q_s;
            tri_n <= 32'(mag(q_s) >> 31);
            m <= '0;
            bidx <= BW'(MW - 1);
          end
          D_ZK2: zk2 <= q_s;
          D_M: zm <= q_s;
          default: ;
        endcase
      end
      OP_TRI: begin
        if (cprod <= (2*MW)'(tri_n)) begin
          m <= c;
        end
        bidx <= bidx - 1'b1;
      end
      OP_SIG1: sig <= sadd(zk2, zm);
      OP_SIG2: begin
        if (zk[IW-1]) begin
          sig <= sadd(sig, -mterm);
        end else if (zk != '0) begin
          sig <= sadd(sig, mterm);
        end
      end
      OP_GATE1: begin
        sig_neg <= sig[IW-1];
        sig_pos <= !sig[IW-1] && (sig != '0);
        ss_mag <= (sig_mag > 64'(SS_ONE)) ? SS_ONE : sig_mag[32:0];
        ta <= 63'(sample_period) * 63'(max_acceleration);
        if (sig[IW-1]) begin
          x <= 34'(max_velocity) - 34'(cv);
        end else if (sig != '0) begin
          x <= 34'(max_velocity) + 34'(cv);
        end else begin
          x <= 34'(max_velocity);
        end
      end
      OP_GATE2: begin
        prod <= 64'(max_acceleration) * 64'(ss_mag);
        // Exact sign of cur_vel*sign(sigma) + max_velocity - T*max_acceleration.
        if (x[33]) begin
          gpos <= 1'b0;
          gzero <= 1'b0;
        end else if (x == '0) begin
          gpos <= 1'b0;
          gzero <= (ta == '0);
        end else if (x[32]) begin
          gpos <= 1'b1;
          gzero <= 1'b0;
        end else begin
          gpos <= {x[31:0], 32'b0} > {1'b0, ta};
          gzero <= {x[31:0], 32'b0} == {1'b0, ta};
        end
      end
      OP_ACC: acc <= sig_pos ? -$signed(amag) : $signed(amag);
      OP_VEL1: pv <= acc[VW-1] ? -$signed(33'(pv_full[63:32]))
                               : $signed(33'(pv_full[63:32]));
      OP_VEL2: vel <= clamp_v(66'(cv) + 66'(pv));
      OP_POS1: pp <= vel[VW-1] ? -$signed(33'(pp_full[63:32]))
                               : $signed(33'(pp_full[63:32]));
      OP_POS2: pos <= clamp_v(66'(cp) + 66'(pp));
      OP_OUT: begin
        cmd_position <= pos;
        cmd_velocity <= vel;
        cmd_acceleration <= acc;
      end
      default: ;
    endcase
  end

  assign status.div_done = div_done;
  assign status.need_fd = need_fd;
  assign status.tri_last = (bidx == '0);
  assign status.out_busy = out_valid;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      (cmd.op == OP_OUT) |-> !out_valid)
    else $error("output word overwritten before it was taken");
  a_sig_sign: assert property (@(posedge clk) disable iff (rst)
      $past(cmd.op == OP_GATE1) |-> !(sig_pos && sig_neg))
    else $error("surface sign both positive and negative");
  a_m_nonzero: assert property (@(posedge clk) disable iff (rst)
      (cmd.op == OP_DSTORE && cmd.sel == D_M) |-> (m != '0))
    else $error("surface index m is zero at its division");

endmodule

@@ sv/mttf_ctrl.sv @@
// Sequencer of the trajectory filter: steps the datapath through one sample.
module mttf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output mttf_pkg::dp_cmd_t     cmd,
  input  mttf_pkg::dp_status_t  status
);
  import mttf_pkg::*;

  state_t   state, state_next;
  div_sel_t sel, sel_next;

  function automatic div_sel_t sel_after(input div_sel_t s);
    unique case (s)
      D_FD: sel_after = D_EK;
      D_EK: sel_after = D_EK2;
      D_EK2: sel_after = D_ZA;
      D_ZA: sel_after = D_ZK;
      D_ZK: sel_after = D_ZK2;
      default: sel_after = D_M;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel <= D_FD;
    end else begin
      state <= state_next;
      sel <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next = sel;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DIV_GO;
          sel_next = D_FD;
        end
      end
      ST_DIV_GO: begin
        if (sel == D_FD && !status.need_fd) begin
          sel_next = D_EK;
        end else begin
          state_next = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          if (sel == D_ZK2) begin
            state_next = ST_TRI;
          end else if (sel == D_M) begin
            state_next = ST_SIG1;
          end else begin
            state_next = ST_DIV_GO;
            sel_next = sel_after(sel);
          end
        end
      end
      ST_TRI: begin
        if (status.tri_last) begin
          state_next = ST_DIV_GO;
          sel_next = D_M;
        end
      end
      ST_SIG1: state_next = ST_SIG2;
      ST_SIG2: state_next = ST_GATE1;
      ST_GATE1: state_next = ST_GATE2;
      ST_GATE2: state_next = ST_ACC;
      ST_ACC: state_next = ST_VEL1;
      ST_VEL1: state_next = ST_VEL2;
      ST_VEL2: state_next = ST_POS1;
      ST_POS1: state_next = ST_POS2;
      ST_POS2: state_next = ST_DONE;
      ST_DONE: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    cmd.div_start = 1'b0;
    cmd.sel = sel;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
        end
      end
      ST_DIV_GO: cmd.div_start = !(sel == D_FD && !status.need_fd);
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.op = OP_DSTORE;
        end
      end
      ST_TRI: cmd.op = OP_TRI;
      ST_SIG1: cmd.op = OP_SIG1;
      ST_SIG2: cmd.op = OP_SIG2;
      ST_GATE1: cmd.op = OP_GATE1;
      ST_GATE2: cmd.op = OP_GATE2;
      ST_ACC: cmd.op = OP_ACC;
      ST_VEL1: cmd.op = OP_VEL1;
      ST_VEL2: cmd.op = OP_VEL2;
      ST_POS1: cmd.op = OP_POS1;
      ST_POS2: cmd.op = OP_POS2;
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.op = OP_OUT;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  a_accept_go: assert property (@(posedge clk) disable iff (rst)
      (in_valid && in_ready) |=> (state == ST_DIV_GO && sel == D_FD))
    else $error("accepted word did not start the sequence");
  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
      cmd.div_start |=> !status.div_done)
    else $error("divider finished in the cycle after its start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
      (state == ST_DONE && !status.out_busy) |=> (state == ST_IDLE))
    else $error("sequencer did not return to idle after the result");

endmodule
